// File: hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Both expect signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mwalu_pkg.sv
`default_nettype none

package mwalu_pkg;

   localparam int unsigned MaxWidth  = 64;
   localparam int unsigned HalfW     = MaxWidth / 2;
   localparam int unsigned ProdW     = 2 * MaxWidth;
   // register stages inside mwalu_mul
   localparam int unsigned MulStages = 4;

   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_ADC  = 3'd1,
      OP_SUB  = 3'd2,
      OP_SBB  = 3'd3,
      OP_MUL  = 3'd4,
      OP_MADD = 3'd5,
      OP_EQ   = 3'd6,
      OP_LE   = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      W8  = 2'd0,
      W16 = 2'd1,
      W32 = 2'd2,
      W64 = 2'd3
   } wsel_type;

   function automatic logic [MaxWidth-1:0] width_mask(wsel_type w);
      logic [MaxWidth-1:0] m;
      case (w)
         W8:      m = MaxWidth'({8{1'b1}});
         W16:     m = MaxWidth'({16{1'b1}});
         W32:     m = MaxWidth'({32{1'b1}});
         default: m = {MaxWidth{1'b1}};
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// File: hdl/mwalu_mul.sv
`default_nettype none

// x*y + z + w over four register stages, split into 32x32 partial products.
module mwalu_mul (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] x,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] y,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] z,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] w,
   output logic      [mwalu_pkg::ProdW-1:0]    prod
);
   import mwalu_pkg::*;

   // stage 1: partial products
   logic [MaxWidth-1:0] ll_ff, lh_ff, hl_ff, hh_ff, z1_ff, w1_ff;
   // stage 2: middle terms and addend sum
   logic [MaxWidth-1:0] ll2_ff, hh2_ff;
   logic [MaxWidth:0]   mid2_ff, zw2_ff;
   // stage 3: full product
   logic [ProdW-1:0]    prod3_ff;
   logic [MaxWidth:0]   zw3_ff;
   // stage 4: accumulated
   logic [ProdW-1:0]    acc4_ff;

   logic [MaxWidth-1:0] ll_in, lh_in, hl_in, hh_in;
   logic [MaxWidth:0]   mid2_in, zw2_in;
   logic [ProdW-1:0]    prod3_in, acc4_in;

   always_comb begin
      ll_in    = MaxWidth'(x[HalfW-1:0]) * MaxWidth'(y[HalfW-1:0]);
      lh_in    = MaxWidth'(x[HalfW-1:0]) * MaxWidth'(y[MaxWidth-1:HalfW]);
      hl_in    = MaxWidth'(x[MaxWidth-1:HalfW]) * MaxWidth'(y[HalfW-1:0]);
      hh_in    = MaxWidth'(x[MaxWidth-1:HalfW]) * MaxWidth'(y[MaxWidth-1:HalfW]);
      mid2_in  = {1'b0, lh_ff} + {1'b0, hl_ff};
      zw2_in   = {1'b0, z1_ff} + {1'b0, w1_ff};
      prod3_in = {hh2_ff, ll2_ff} + (ProdW'(mid2_ff) << HalfW);
      acc4_in  = prod3_ff + ProdW'(zw3_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff    <= ll_in;
         lh_ff    <= lh_in;
         hl_ff    <= hl_in;
         hh_ff    <= hh_in;
         z1_ff    <= z;
         w1_ff    <= w;
         ll2_ff   <= ll_ff;
         hh2_ff   <= hh_ff;
         mid2_ff  <= mid2_in;
         zw2_ff   <= zw2_in;
         prod3_ff <= prod3_in;
         zw3_ff   <= zw2_ff;
         acc4_ff  <= acc4_in;
      end
   end

   assign prod = acc4_ff;

endmodule

`default_nettype wire

// File: hdl/multiwidth_integer_alu_top.sv
// Multi-width unsigned integer ALU (8, 16, 32 or 64 bit operands).
// Request channel: req_valid/req_ready with the opcode, width select, carry or
// borrow in and four operands. Operands are masked to the selected width.
// Response channel: rsp_valid/rsp_ready with flag, result_hi and result_lo.
// Ops: add, add with carry, sub, sub with borrow, mul, mul-add-add, eq, le.
// Every request gives exactly one response, in request order.
// Every op passes through the same pipeline registers.
// Throughput: one request per cycle when not stalled; the six-deep pipeline
// (input register, four multiplier stages, output register) advances as one.
// The 64x64 product is built from four 32x32 partial products, summed over
// two stages, then the two addends are added in a further stage.
// Stall: while a response waits unaccepted the whole pipeline holds and
// req_ready is low; nothing is dropped or repeated. With the output taken or
// empty, req_ready is high even while earlier requests are in flight.
// Reset (synchronous, active high) empties the pipeline; no other state.
`default_nettype none

`include "assert_macros.svh"

module multiwidth_integer_alu_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire mwalu_pkg::op_type             req_type,
   input  wire mwalu_pkg::wsel_type           req_width_sel,
   input  wire logic                          req_carry_in,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] req_operand_a,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] req_operand_b,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] req_addend_c,
   input  wire logic [mwalu_pkg::MaxWidth-1:0] req_addend_d,
   // response channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_flag,
   output logic      [mwalu_pkg::MaxWidth-1:0] rsp_result_hi,
   output logic      [mwalu_pkg::MaxWidth-1:0] rsp_result_lo
);
   import mwalu_pkg::*;

   // add/sub/compare result carried alongside the multiplier stages
   typedef struct packed {
      op_type              op;
      wsel_type            wsel;
      logic                flag;
      logic [MaxWidth-1:0] lo;
   } side_type;

   logic en;

   // stage 0: masked request
   logic                vld0_ff;
   op_type              op0_ff;
   wsel_type            wsel0_ff;
   logic                cin0_ff;
   logic [MaxWidth-1:0] a0_ff, b0_ff, c0_ff, d0_ff;

   logic [MaxWidth-1:0] mask_in;
   logic                cin0_in;
   logic [MaxWidth-1:0] c0_in, d0_in;

   // stages 1..MulStages: side band
   logic [MulStages:1]  vld_ff;
   side_type            side_ff [1:MulStages];
   side_type            side_in;
   logic [MaxWidth:0]   sum_in, diff_in;

   logic [ProdW-1:0]    prod;

   // output register
   logic                rsp_valid_ff;
   logic                flag_ff, flag_in;
   logic [MaxWidth-1:0] hi_ff, hi_in, lo_ff, lo_in;
   op_type              out_op_ff;
   wsel_type            out_w_ff;

   // assertion helpers
   logic                rsp_cmp, rsp_addsub, rsp_mul, rsp_w8, upper_set;
   logic                stalled, tail_vld;

   // whole pipeline moves when the output slot is free or being taken
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // input masking; addends only matter to mul-add-add, carry only to adc/sbb
   always_comb begin
      mask_in = width_mask(req_width_sel);
      cin0_in = (req_type == OP_ADC || req_type == OP_SBB) ? req_carry_in : 1'b0;
      c0_in   = (req_type == OP_MADD) ? (req_addend_c & mask_in) : '0;
      d0_in   = (req_type == OP_MADD) ? (req_addend_d & mask_in) : '0;
   end

   // add, subtract and compare in stage 1
   always_comb begin
      sum_in  = {1'b0, a0_ff} + {1'b0, b0_ff} + (MaxWidth+1)'(cin0_ff);
      diff_in = {1'b0, a0_ff} - {1'b0, b0_ff} - (MaxWidth+1)'(cin0_ff);
      side_in.op   = op0_ff;
      side_in.wsel = wsel0_ff;
      side_in.flag = 1'b0;
      side_in.lo   = '0;
      case (op0_ff)
         OP_ADD, OP_ADC: begin
            side_in.lo = sum_in[MaxWidth-1:0] & width_mask(wsel0_ff);
            case (wsel0_ff)
               W8:      side_in.flag = sum_in[8];
               W16:     side_in.flag = sum_in[16];
               W32:     side_in.flag = sum_in[32];
               default: side_in.flag = sum_in[MaxWidth];
            endcase
         end
         OP_SUB, OP_SBB: begin
            // operands below 2^n, so any borrow shows in the top bit
            side_in.lo   = diff_in[MaxWidth-1:0] & width_mask(wsel0_ff);
            side_in.flag = diff_in[MaxWidth];
         end
         OP_EQ:   side_in.flag = (a0_ff == b0_ff);
         OP_LE:   side_in.flag = (a0_ff <= b0_ff);
         default: side_in.flag = 1'b0;
      endcase
   end

   mwalu_mul u_mul (
      .clock (clock),
      .en    (en),
      .x     (a0_ff),
      .y     (b0_ff),
      .z     (c0_ff),
      .w     (d0_ff),
      .prod  (prod)
   );

   // final selection: product halves by width, else side-band result
   always_comb begin
      flag_in = side_ff[MulStages].flag;
      hi_in   = '0;
      lo_in   = side_ff[MulStages].lo;
      if (side_ff[MulStages].op inside {OP_MUL, OP_MADD}) begin
         case (side_ff[MulStages].wsel)
            W8: begin
               hi_in = MaxWidth'(prod[15:8]);
               lo_in = MaxWidth'(prod[7:0]);
            end
            W16: begin
               hi_in = MaxWidth'(prod[31:16]);
               lo_in = MaxWidth'(prod[15:0]);
            end
            W32: begin
               hi_in = MaxWidth'(prod[63:32]);
               lo_in = MaxWidth'(prod[31:0]);
            end
            default: begin
               hi_in = prod[ProdW-1:MaxWidth];
               lo_in = prod[MaxWidth-1:0];
            end
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff      <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld0_ff      <= req_valid;
         vld_ff       <= {vld_ff[MulStages-1:1], vld0_ff};
         rsp_valid_ff <= vld_ff[MulStages];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff     <= req_type;
         wsel0_ff   <= req_width_sel;
         cin0_ff    <= cin0_in;
         a0_ff      <= req_operand_a & mask_in;
         b0_ff      <= req_operand_b & mask_in;
         c0_ff      <= c0_in;
         d0_ff      <= d0_in;
         side_ff[1] <= side_in;
         for (int i = 2; i <= MulStages; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         flag_ff    <= flag_in;
         hi_ff      <= hi_in;
         lo_ff      <= lo_in;
         out_op_ff  <= side_ff[MulStages].op;
         out_w_ff   <= side_ff[MulStages].wsel;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_flag      = flag_ff;
   assign rsp_result_hi = hi_ff;
   assign rsp_result_lo = lo_ff;

   assign rsp_cmp    = rsp_valid_ff && (out_op_ff inside {OP_EQ, OP_LE});
   assign rsp_addsub = rsp_valid_ff && (out_op_ff inside {OP_ADD, OP_ADC, OP_SUB, OP_SBB});
   assign rsp_mul    = rsp_valid_ff && (out_op_ff inside {OP_MUL, OP_MADD});
   assign rsp_w8     = rsp_valid_ff && (out_w_ff == W8);
   assign upper_set  = |{hi_ff[MaxWidth-1:8], lo_ff[MaxWidth-1:8]};
   assign stalled    = rsp_valid_ff && !rsp_ready;
   assign tail_vld   = vld_ff[MulStages];

   `ASSERT_IMPL(a_cmp_words_zero, rsp_cmp, hi_ff == '0 && lo_ff == '0, "compare words non-zero")
   `ASSERT_IMPL(a_addsub_hi_zero, rsp_addsub, hi_ff == '0, "add/sub high word non-zero")
   `ASSERT_IMPL(a_mul_flag_zero, rsp_mul, !flag_ff, "multiply response with flag set")
   `ASSERT_IMPL(a_w8_in_range, rsp_w8, !upper_set, "8-bit response wider than 8 bits")
   `ASSERT_NEXT(a_stall_holds, stalled && tail_vld, tail_vld && rsp_valid_ff, "moved in stall")

endmodule

`default_nettype wire
